### hdl/cbadm_pkg.sv
package cbadm_pkg;

  // field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned SHARD_W    = 4;
  localparam int unsigned VERDICT_W  = 3;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned LEVEL_W    = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // stream packing widths
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned S_TUSER_W = OP_W;
  localparam int unsigned M_TDATA_W = 16;

  // register reset values
  localparam logic [INTERVAL_W-1:0] OPEN_INTERVAL_RST  = 16'd1000;
  localparam logic [LEVEL_W-1:0]    QUEUE_CAPACITY_RST = 10'd341;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_INTERVAL  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CAPACITY = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ARRIVAL = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_OUTCOME = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  typedef enum logic [VERDICT_W-1:0] {
    V_QUEUED     = 3'd0,
    V_REJ_OPEN   = 3'd1,
    V_REJ_FULL   = 3'd2,
    V_FORWARD    = 3'd3,
    V_FAIL_FAST  = 3'd4,
    V_RECORDED   = 3'd5,
    V_QUEUE_EMPTY = 3'd6
  } verdict_t;

  typedef struct packed {
    op_t                operation;
    logic [SHARD_W-1:0] shard;
    logic               backend_failed;
  } event_t;

  typedef struct packed {
    verdict_t           verdict;
    logic               circuit_open;
    logic [LEVEL_W-1:0] queue_level;
  } result_t;

endpackage

### hdl/shard_circuit_breaker_admission.sv
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tuser: operation; s_tdata: shard, backend_failed
// m_*       out  m_tvalid/m_tready  m_tdata: verdict, circuit_open, queue_level
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// one event per cycle sustained while m_tready stays high
// an event is registered, then a shard read-modify-write runs into the result register
// a tick updates every countdown in the same cycle
// synchronous reset clears all shards, config returns to 1000 ticks / 341 entries
// a stalled m side holds the result; s_tready drops only when both stages are full and m_tready is low
module shard_circuit_breaker_admission #(
  parameter int unsigned NUM_SHARDS = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [cbadm_pkg::S_TDATA_W-1:0]     s_tdata,  // shard[3:0], backend_failed[4], zero
  input  logic [cbadm_pkg::S_TUSER_W-1:0]     s_tuser,  // operation[1:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [cbadm_pkg::M_TDATA_W-1:0]     m_tdata,  // verdict[2:0], circuit_open[3],
                                                        // queue_level[13:4], zero
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cbadm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbadm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [cbadm_pkg::INTERVAL_W-1:0] open_interval;
  logic [cbadm_pkg::LEVEL_W-1:0]    queue_capacity;
  logic                             in_valid;
  cbadm_pkg::event_t                in_evt;
  logic                             out_free;
  logic                             advance;
  cbadm_pkg::result_t               step_result;
  cbadm_pkg::result_t               out_result;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      open_interval  <= cbadm_pkg::OPEN_INTERVAL_RST;
      queue_capacity <= cbadm_pkg::QUEUE_CAPACITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cbadm_pkg::CFG_OPEN_INTERVAL:  open_interval  <= cfg_data[cbadm_pkg::INTERVAL_W-1:0];
        cbadm_pkg::CFG_QUEUE_CAPACITY: queue_capacity <= cfg_data[cbadm_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_evt.operation      <= cbadm_pkg::op_t'(s_tuser);
      in_evt.shard          <= s_tdata[cbadm_pkg::SHARD_W-1:0];
      in_evt.backend_failed <= s_tdata[cbadm_pkg::SHARD_W];
    end
  end

  cbadm_shard_state #(
    .NUM_SHARDS(NUM_SHARDS)
  ) u_state (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .evt           (in_evt),
    .open_interval (open_interval),
    .queue_capacity(queue_capacity),
    .result        (step_result)
  );

  cbadm_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result_in (step_result),
    .free      (out_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result_out(out_result)
  );

  // output packing
  assign m_tdata = {2'b00, out_result.queue_level, out_result.circuit_open,
                    out_result.verdict};

endmodule

### hdl/cbadm_shard_state.sv
module cbadm_shard_state #(
  parameter int unsigned NUM_SHARDS = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  cbadm_pkg::event_t                   evt,
  input  logic [cbadm_pkg::INTERVAL_W-1:0]    open_interval,
  input  logic [cbadm_pkg::LEVEL_W-1:0]       queue_capacity,
  output cbadm_pkg::result_t                  result
);

  localparam int unsigned IDX_W = (NUM_SHARDS > 1) ? $clog2(NUM_SHARDS) : 1;
  localparam logic [cbadm_pkg::SHARD_W:0] SHARD_LIMIT = (cbadm_pkg::SHARD_W+1)'(NUM_SHARDS);

  // per-shard breaker and queue state
  logic                             open_flag      [NUM_SHARDS];
  logic                             probe_pending  [NUM_SHARDS];
  logic [cbadm_pkg::INTERVAL_W-1:0] open_remaining [NUM_SHARDS];
  logic [cbadm_pkg::LEVEL_W-1:0]    queue_count    [NUM_SHARDS];

  logic                             open_flag_next      [NUM_SHARDS];
  logic                             probe_pending_next  [NUM_SHARDS];
  logic [cbadm_pkg::INTERVAL_W-1:0] open_remaining_next [NUM_SHARDS];
  logic [cbadm_pkg::LEVEL_W-1:0]    queue_count_next    [NUM_SHARDS];

  logic                             sel_valid;
  logic [IDX_W-1:0]                 idx;
  logic                             is_tick;
  logic                             cur_flag;
  logic                             cur_probe;
  logic [cbadm_pkg::INTERVAL_W-1:0] cur_rem;
  logic [cbadm_pkg::LEVEL_W-1:0]    cur_count;
  logic                             new_flag;
  logic                             new_probe;
  logic [cbadm_pkg::INTERVAL_W-1:0] new_rem;
  logic [cbadm_pkg::LEVEL_W-1:0]    new_count;
  cbadm_pkg::verdict_t              verdict;

  assign sel_valid = {1'b0, evt.shard} < SHARD_LIMIT;
  assign idx       = evt.shard[IDX_W-1:0];
  assign is_tick   = (evt.operation == cbadm_pkg::OP_TICK);

  // selected shard read
  assign cur_flag  = open_flag[idx];
  assign cur_probe = probe_pending[idx];
  assign cur_rem   = open_remaining[idx];
  assign cur_count = queue_count[idx];

  // event decision for the selected shard
  always_comb begin
    new_flag  = cur_flag;
    new_probe = cur_probe;
    new_rem   = cur_rem;
    new_count = cur_count;
    verdict   = cbadm_pkg::V_RECORDED;
    if (!sel_valid) begin
      unique case (evt.operation)
        cbadm_pkg::OP_ARRIVAL: verdict = cbadm_pkg::V_REJ_FULL;
        cbadm_pkg::OP_DEQUEUE: verdict = cbadm_pkg::V_QUEUE_EMPTY;
        default:               verdict = cbadm_pkg::V_RECORDED;
      endcase
    end else begin
      unique case (evt.operation)
        cbadm_pkg::OP_ARRIVAL: begin
          if (cur_flag && (cur_rem != '0)) begin
            verdict = cbadm_pkg::V_REJ_OPEN;
          end else if (cur_count >= queue_capacity) begin
            verdict = cbadm_pkg::V_REJ_FULL;
          end else begin
            new_count = cur_count + 1'b1;
            verdict   = cbadm_pkg::V_QUEUED;
          end
        end
        cbadm_pkg::OP_DEQUEUE: begin
          if (cur_count == '0) begin
            verdict = cbadm_pkg::V_QUEUE_EMPTY;
          end else begin
            new_count = cur_count - 1'b1;
            if (!cur_flag) begin
              verdict = cbadm_pkg::V_FORWARD;
            end else if ((cur_rem != '0) || cur_probe) begin
              verdict = cbadm_pkg::V_FAIL_FAST;
            end else begin
              // countdown over: let one probe through
              new_probe = 1'b1;
              verdict   = cbadm_pkg::V_FORWARD;
            end
          end
        end
        cbadm_pkg::OP_OUTCOME: begin
          new_probe = 1'b0;
          if (evt.backend_failed) begin
            new_flag = 1'b1;
            new_rem  = open_interval;
          end else begin
            new_flag = 1'b0;
          end
        end
        default: verdict = cbadm_pkg::V_RECORDED;
      endcase
    end
  end

  // next state: tick walks all countdowns, other events touch one shard
  always_comb begin
    for (int i = 0; i < NUM_SHARDS; i++) begin
      open_flag_next[i]      = open_flag[i];
      probe_pending_next[i]  = probe_pending[i];
      open_remaining_next[i] = open_remaining[i];
      queue_count_next[i]    = queue_count[i];
      if (is_tick) begin
        if (open_remaining[i] != '0) begin
          open_remaining_next[i] = open_remaining[i] - 1'b1;
        end
      end else if (sel_valid && (idx == IDX_W'(i))) begin
        open_flag_next[i]      = new_flag;
        probe_pending_next[i]  = new_probe;
        open_remaining_next[i] = new_rem;
        queue_count_next[i]    = new_count;
      end
    end
  end

  // result seen after the step
  always_comb begin
    result.verdict      = verdict;
    result.circuit_open = sel_valid && open_flag_next[idx] && (open_remaining_next[idx] != '0);
    result.queue_level  = sel_valid ? queue_count_next[idx] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SHARDS; i++) begin
        open_flag[i]      <= 1'b0;
        probe_pending[i]  <= 1'b0;
        open_remaining[i] <= '0;
        queue_count[i]    <= '0;
      end
    end else if (step) begin
      for (int i = 0; i < NUM_SHARDS; i++) begin
        open_flag[i]      <= open_flag_next[i];
        probe_pending[i]  <= probe_pending_next[i];
        open_remaining[i] <= open_remaining_next[i];
        queue_count[i]    <= queue_count_next[i];
      end
    end
  end

endmodule

### hdl/cbadm_result_reg.sv
module cbadm_result_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  cbadm_pkg::result_t   result_in,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cbadm_pkg::result_t   result_out
);

  // slot frees in the same cycle the held result is taken
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      result_out <= result_in;
    end
  end

endmodule

### hdl/cbadm_checker.sv
module cbadm_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [cbadm_pkg::M_TDATA_W-1:0]  m_tdata
);

  // held result does not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no result in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // an accepted arrival leaves a nonempty queue
  a_queued_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == 3'(cbadm_pkg::V_QUEUED)) |-> (m_tdata[13:4] != '0))
    else $error("queued with empty queue");

  // empty verdict reports an empty queue
  a_empty_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == 3'(cbadm_pkg::V_QUEUE_EMPTY)) |-> (m_tdata[13:4] == '0))
    else $error("queue empty verdict with nonzero level");

  // open rejection only with a running open circuit
  a_rej_open: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == 3'(cbadm_pkg::V_REJ_OPEN)) |-> m_tdata[3])
    else $error("rejected open while circuit closed");

endmodule

bind shard_circuit_breaker_admission cbadm_checker u_cbadm_checker (.*);
